/* design/php_pkg.sv */
`default_nettype none
package php_pkg;

    localparam logic [15:0] ET_IPV4 = 16'h0800;
    localparam logic [15:0] ET_ARP  = 16'h0806;
    localparam logic [15:0] ET_IPV6 = 16'h86DD;
    localparam logic [15:0] ET_VLAN = 16'h8100;
    localparam logic [15:0] ET_QINQ = 16'h88A8;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [1:0] MODE_ETH    = 2'd0;
    localparam logic [1:0] MODE_COOKED = 2'd1;
    localparam logic [1:0] MODE_NULL   = 2'd2;

    localparam logic [7:0] PROTO_ICMP   = 8'd1;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [7:0] PROTO_ICMP6  = 8'd58;
    localparam logic [7:0] NH_HOP       = 8'd0;
    localparam logic [7:0] NH_ROUTING   = 8'd43;
    localparam logic [7:0] NH_FRAGMENT  = 8'd44;
    localparam logic [7:0] NH_DEST_OPTS = 8'd60;

    localparam logic [15:0] PORT_DNS  = 16'd53;
    localparam logic [15:0] PORT_MDNS = 16'd5353;

    typedef struct packed {
        logic [15:0] seen_len;
        logic [15:0] wire_length;
        logic [2:0]  ipver;
        logic [31:0] src_key;
        logic [31:0] dst_key;
        logic [7:0]  protocol;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  flag_bits;
        logic        is_arp;
        logic        is_icmp;
        logic        is_dns;
    } result_t;

    function automatic logic [4:0] link_length(input logic [1:0] mode);
        case (mode)
            MODE_ETH:    link_length = 5'd14;
            MODE_COOKED: link_length = 5'd16;
            MODE_NULL:   link_length = 5'd4;
            default:     link_length = 5'd0;
        endcase
    endfunction

    function automatic logic is_tag(input logic [15:0] et);
        is_tag = (et == ET_VLAN) || (et == ET_QINQ);
    endfunction

    function automatic logic is_ext(input logic [7:0] nh);
        is_ext = (nh == NH_HOP) || (nh == NH_ROUTING) || (nh == NH_FRAGMENT)
            || (nh == NH_DEST_OPTS);
    endfunction

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        fnv_step = (h ^ {24'd0, b}) * FNV_PRIME;
    endfunction

endpackage
`default_nettype wire

/* design/packet_header_parser_unit.sv */
// packet header parser
// s_ channel: one captured packet byte per request (s_data_byte), with
// s_last_byte on the final byte and s_wire_len taken from that final byte.
// m_ channel: one header summary per packet, sent after the last byte.
// cfg channel: writes link_mode (cfg_data); cfg_ready is always high, write
// only while no packet is in progress.
// each byte updates the parse state directly, so the block sustains one byte
// per cycle unless a last byte is held off. the summary appears on m_ in the
// cycle after the last byte is accepted and is held in an output register.
// the next packet's bytes are accepted while a summary waits; only a new
// last byte is held off (s_ready low) while an untaken summary sits in the
// output register and m_ready is low.
// reset clears link_mode to ethernet, all parse state and m_valid.
// after each summary the parse state clears so the next byte starts a packet.
// the byte count saturates at 65535.
`default_nettype none
module packet_header_parser_unit #(
    parameter int MAX_EXTENSIONS = 8,
    parameter int MAX_TAGS       = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_last_byte,
    input  wire logic [15:0] s_wire_len,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_seen_len,
    output logic [15:0]      m_wire_length,
    output logic [2:0]       m_ipver,
    output logic [31:0]      m_src_key,
    output logic [31:0]      m_dst_key,
    output logic [7:0]       m_protocol,
    output logic [15:0]      m_sport,
    output logic [15:0]      m_dport,
    output logic [7:0]       m_flag_bits,
    output logic             m_is_arp,
    output logic             m_is_icmp,
    output logic             m_is_dns
);

    logic [1:0]  link_mode_reg;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [31:0] link_word_reg, link_word_next;
    logic [15:0] ether_type_reg, ether_type_next;
    logic [1:0]  tag_count_reg, tag_count_next;
    logic [15:0] net_start_reg, net_start_next;
    logic [7:0]  ver_len_reg, ver_len_next;
    logic [31:0] source_word_reg, source_word_next;
    logic [31:0] dest_word_reg, dest_word_next;
    logic [7:0]  next_proto_reg, next_proto_next;
    logic [7:0]  pending_next_reg, pending_next_next;
    logic [3:0]  ext_count_reg, ext_count_next;
    logic [15:0] trans_start_reg, trans_start_next;
    logic [31:0] port_pair_reg, port_pair_next;
    logic [7:0]  flags_byte_reg, flags_byte_next;

    logic                 m_valid_reg;
    php_pkg::result_t     res_reg;
    php_pkg::result_t     res_next;

    logic        accept;
    logic [4:0]  link_len;
    logic [15:0] pos;
    logic [15:0] rel;
    logic [15:0] trel;
    logic [15:0] erel;

    assign cfg_ready = 1'b1;
    assign s_ready   = !s_last_byte || !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign link_len  = php_pkg::link_length(link_mode_reg);
    assign pos       = byte_count_reg;

    // per-byte parse step
    always_comb begin
        byte_count_next   = byte_count_reg;
        link_word_next    = link_word_reg;
        ether_type_next   = ether_type_reg;
        tag_count_next    = tag_count_reg;
        net_start_next    = net_start_reg;
        ver_len_next      = ver_len_reg;
        source_word_next  = source_word_reg;
        dest_word_next    = dest_word_reg;
        next_proto_next   = next_proto_reg;
        pending_next_next = pending_next_reg;
        ext_count_next    = ext_count_reg;
        trans_start_next  = trans_start_reg;
        port_pair_next    = port_pair_reg;
        flags_byte_next   = flags_byte_reg;
        rel  = pos - net_start_reg;
        trel = pos - trans_start_reg;
        erel = pos - trans_start_reg;

        if (byte_count_reg != 16'hFFFF) begin
            byte_count_next = byte_count_reg + 16'd1;
        end

        if (link_len != 5'd0) begin
            if (pos < {11'd0, link_len}) begin
                if (link_mode_reg == php_pkg::MODE_ETH && (pos == 16'd12 || pos == 16'd13)) begin
                    ether_type_next = {ether_type_reg[7:0], s_data_byte};
                end else if (link_mode_reg == php_pkg::MODE_COOKED
                        && (pos == 16'd14 || pos == 16'd15)) begin
                    ether_type_next = {ether_type_reg[7:0], s_data_byte};
                end else if (link_mode_reg == php_pkg::MODE_NULL && pos < 16'd4) begin
                    // family word is little-endian
                    link_word_next = link_word_reg
                        | ({24'd0, s_data_byte} << {pos[1:0], 3'b000});
                    if (pos == 16'd3) begin
                        ether_type_next = (link_word_next == 32'd2) ?
                            php_pkg::ET_IPV4 : php_pkg::ET_IPV6;
                    end
                end
                if (pos + 16'd1 == {11'd0, link_len}) begin
                    net_start_next = {11'd0, link_len};
                end
            end else if (pos >= net_start_reg) begin
                if (php_pkg::is_tag(ether_type_reg)
                        && 32'(tag_count_reg) < MAX_TAGS) begin
                    if (rel == 16'd2) begin
                        link_word_next = {24'd0, s_data_byte};
                    end else if (rel == 16'd3) begin
                        ether_type_next = {link_word_reg[7:0], s_data_byte};
                        net_start_next  = net_start_reg + 16'd4;
                        tag_count_next  = tag_count_reg + 2'd1;
                    end
                end else if (ether_type_reg == php_pkg::ET_IPV4) begin
                    if (rel < 16'd20) begin
                        if (rel == 16'd0) begin
                            ver_len_next     = s_data_byte;
                            trans_start_next = net_start_reg
                                + {10'd0, s_data_byte[3:0], 2'b00};
                        end else if (rel == 16'd9) begin
                            next_proto_next = s_data_byte;
                        end else if (rel >= 16'd12 && rel < 16'd16) begin
                            source_word_next = {source_word_reg[23:0], s_data_byte};
                        end else if (rel >= 16'd16) begin
                            dest_word_next = {dest_word_reg[23:0], s_data_byte};
                        end
                    end else if (pos >= trans_start_reg) begin
                        if (trel < 16'd4) begin
                            port_pair_next = {port_pair_reg[23:0], s_data_byte};
                        end else if (trel == 16'd13) begin
                            flags_byte_next = s_data_byte;
                        end
                    end
                end else if (ether_type_reg == php_pkg::ET_IPV6) begin
                    if (rel < 16'd40) begin
                        if (rel == 16'd0) begin
                            trans_start_next = net_start_reg + 16'd40;
                        end else if (rel == 16'd6) begin
                            pending_next_next = s_data_byte;
                        end else if (rel >= 16'd8 && rel < 16'd24) begin
                            source_word_next = php_pkg::fnv_step(
                                (rel == 16'd8) ? php_pkg::FNV_BASIS : source_word_reg,
                                s_data_byte);
                        end else if (rel >= 16'd24) begin
                            dest_word_next = php_pkg::fnv_step(
                                (rel == 16'd24) ? php_pkg::FNV_BASIS : dest_word_reg,
                                s_data_byte);
                        end
                    end else if (32'(ext_count_reg) < MAX_EXTENSIONS
                            && php_pkg::is_ext(pending_next_reg)) begin
                        if (pos >= trans_start_reg) begin
                            if (erel == 16'd0) begin
                                next_proto_next = s_data_byte;
                            end else if (erel == 16'd1) begin
                                // fragment header is fixed at 8 bytes
                                trans_start_next = trans_start_reg
                                    + ((pending_next_reg == php_pkg::NH_FRAGMENT) ? 16'd8 :
                                       ({5'd0, s_data_byte, 3'b000} + 16'd8));
                                pending_next_next = next_proto_reg;
                                ext_count_next    = ext_count_reg + 4'd1;
                            end
                        end
                    end else if (pos >= trans_start_reg) begin
                        if (trel < 16'd4) begin
                            port_pair_next = {port_pair_reg[23:0], s_data_byte};
                        end else if (trel == 16'd13) begin
                            flags_byte_next = s_data_byte;
                        end
                    end
                end
            end
        end
    end

    // summary from the state after the last byte
    always_comb begin
        logic [16:0] cnt;
        logic [16:0] ns;
        logic [16:0] ts;
        logic [16:0] ihl;
        res_next = '0;
        cnt = {1'b0, byte_count_next};
        ns  = {1'b0, net_start_next};
        ts  = {1'b0, trans_start_next};
        ihl = {11'd0, ver_len_next[3:0], 2'b00};
        res_next.seen_len    = byte_count_next;
        res_next.wire_length = s_wire_len;
        if (link_len != 5'd0 && cnt >= {12'd0, link_len}) begin
            if (ether_type_next == php_pkg::ET_ARP) begin
                res_next.is_arp = 1'b1;
            end else if (ether_type_next == php_pkg::ET_IPV4) begin
                if (cnt >= ns + 17'd20 && ver_len_next[7:4] == 4'd4
                        && ihl >= 17'd20 && cnt >= ns + ihl) begin
                    res_next.ipver    = 3'd4;
                    res_next.src_key  = source_word_next;
                    res_next.dst_key  = dest_word_next;
                    res_next.protocol = next_proto_next;
                    if (next_proto_next == php_pkg::PROTO_ICMP) begin
                        res_next.is_icmp = 1'b1;
                    end else if (next_proto_next == php_pkg::PROTO_TCP
                            && cnt >= ts + 17'd20) begin
                        res_next.sport     = port_pair_next[31:16];
                        res_next.dport     = port_pair_next[15:0];
                        res_next.flag_bits = flags_byte_next;
                        res_next.is_dns = (port_pair_next[31:16] == php_pkg::PORT_DNS)
                            || (port_pair_next[15:0] == php_pkg::PORT_DNS);
                    end else if (next_proto_next == php_pkg::PROTO_UDP
                            && cnt >= ts + 17'd8) begin
                        res_next.sport = port_pair_next[31:16];
                        res_next.dport = port_pair_next[15:0];
                        res_next.is_dns = (port_pair_next[31:16] == php_pkg::PORT_DNS)
                            || (port_pair_next[15:0] == php_pkg::PORT_DNS)
                            || (port_pair_next[31:16] == php_pkg::PORT_MDNS)
                            || (port_pair_next[15:0] == php_pkg::PORT_MDNS);
                    end
                end
            end else if (ether_type_next == php_pkg::ET_IPV6) begin
                if (cnt >= ns + 17'd40) begin
                    res_next.ipver    = 3'd6;
                    res_next.src_key  = source_word_next;
                    res_next.dst_key  = dest_word_next;
                    res_next.protocol = pending_next_next;
                    if ((pending_next_next == php_pkg::PROTO_TCP && cnt >= ts + 17'd20)
                            || (pending_next_next == php_pkg::PROTO_UDP
                            && cnt >= ts + 17'd8)) begin
                        res_next.sport = port_pair_next[31:16];
                        res_next.dport = port_pair_next[15:0];
                        res_next.is_dns = (port_pair_next[31:16] == php_pkg::PORT_DNS)
                            || (port_pair_next[15:0] == php_pkg::PORT_DNS);
                    end
                    if (pending_next_next == php_pkg::PROTO_TCP && cnt >= ts + 17'd20) begin
                        res_next.flag_bits = flags_byte_next;
                    end
                    res_next.is_icmp = (pending_next_next == php_pkg::PROTO_ICMP6);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_mode_reg    <= php_pkg::MODE_ETH;
            byte_count_reg   <= '0;
            link_word_reg    <= '0;
            ether_type_reg   <= '0;
            tag_count_reg    <= '0;
            net_start_reg    <= '0;
            ver_len_reg      <= '0;
            source_word_reg  <= '0;
            dest_word_reg    <= '0;
            next_proto_reg   <= '0;
            pending_next_reg <= '0;
            ext_count_reg    <= '0;
            trans_start_reg  <= '0;
            port_pair_reg    <= '0;
            flags_byte_reg   <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid) begin
                link_mode_reg <= cfg_data;
            end
            if (accept && s_last_byte) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                if (s_last_byte) begin
                    byte_count_reg   <= '0;
                    link_word_reg    <= '0;
                    ether_type_reg   <= '0;
                    tag_count_reg    <= '0;
                    net_start_reg    <= '0;
                    ver_len_reg      <= '0;
                    source_word_reg  <= '0;
                    dest_word_reg    <= '0;
                    next_proto_reg   <= '0;
                    pending_next_reg <= '0;
                    ext_count_reg    <= '0;
                    trans_start_reg  <= '0;
                    port_pair_reg    <= '0;
                    flags_byte_reg   <= '0;
                end else begin
                    byte_count_reg   <= byte_count_next;
                    link_word_reg    <= link_word_next;
                    ether_type_reg   <= ether_type_next;
                    tag_count_reg    <= tag_count_next;
                    net_start_reg    <= net_start_next;
                    ver_len_reg      <= ver_len_next;
                    source_word_reg  <= source_word_next;
                    dest_word_reg    <= dest_word_next;
                    next_proto_reg   <= next_proto_next;
                    pending_next_reg <= pending_next_next;
                    ext_count_reg    <= ext_count_next;
                    trans_start_reg  <= trans_start_next;
                    port_pair_reg    <= port_pair_next;
                    flags_byte_reg   <= flags_byte_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_last_byte) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_seen_len    = res_reg.seen_len;
    assign m_wire_length = res_reg.wire_length;
    assign m_ipver       = res_reg.ipver;
    assign m_src_key     = res_reg.src_key;
    assign m_dst_key     = res_reg.dst_key;
    assign m_protocol    = res_reg.protocol;
    assign m_sport       = res_reg.sport;
    assign m_dport       = res_reg.dport;
    assign m_flag_bits   = res_reg.flag_bits;
    assign m_is_arp      = res_reg.is_arp;
    assign m_is_icmp     = res_reg.is_icmp;
    assign m_is_dns      = res_reg.is_dns;

    a_summary_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(accept && s_last_byte))
        else $error("summary without a last byte");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_last_byte |=> byte_count_reg == 16'd0 && ether_type_reg == 16'd0)
        else $error("parse state not cleared after packet");

    a_nonzero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> res_reg.seen_len != 16'd0)
        else $error("summary with zero captured length");

endmodule
`default_nettype wire
